/* sv/wlsm_pkg.sv */
package wlsm_pkg;

   // fixed number of influence columns carried by one input word
   localparam int NCOL = 4;

   localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

   // result kinds
   localparam logic [1:0] KIND_STAT = 2'd0;
   localparam logic [1:0] KIND_EXP  = 2'd1;
   localparam logic [1:0] KIND_COV  = 2'd2;
   localparam logic [1:0] KIND_ERR  = 2'd3;

   typedef struct packed {
      logic signed [31:0] x_value;
      logic [15:0]        case_weight;
      logic signed [31:0] y_col0;
      logic signed [31:0] y_col1;
      logic signed [31:0] y_col2;
      logic signed [31:0] y_col3;
      logic               last_observation;
   } req_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic [1:0]         row_index;
      logic [1:0]         col_index;
      logic signed [63:0] result_value;
      logic               last_result;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic               frac_shift;
      logic signed [63:0] a;
      logic signed [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               done;
      logic signed [63:0] fx;
      logic signed [63:0] lo;
   } mul_rsp_type;

   typedef struct packed {
      logic               start;
      logic signed [63:0] num;
      logic [63:0]        den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic signed [63:0] quo;
   } div_rsp_type;

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
      return s[63:0];
   endfunction

endpackage

/* sv/wlsm_mul.sv */
// Shared 64x64 signed multiplier: four 32x32 partial products accumulated in
// turn, then truncating shift and saturation. Also gives the wrapped low word.
module wlsm_mul #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  wlsm_pkg::mul_req_type req,
   output wlsm_pkg::mul_rsp_type rsp
);
   logic [63:0]  ua_ff, ub_ff;
   logic         neg_ff, frac_ff;
   logic [2:0]   cnt_ff;
   logic         busy_ff, done_ff;
   logic [63:0]  pp_ff;
   logic [1:0]   pos_ff;
   logic [127:0] acc_ff;
   logic [127:0] pp_shift;
   logic [127:0] mag_sh;
   logic [63:0]  lo_mag;
   logic [31:0]  pa, pb;

   // partial product operands
   always_comb begin
      pa = cnt_ff[0] ? ua_ff[63:32] : ua_ff[31:0];
      pb = cnt_ff[1] ? ub_ff[63:32] : ub_ff[31:0];
      case (pos_ff)
         2'd0:    pp_shift = {64'd0, pp_ff};
         2'd1:    pp_shift = {32'd0, pp_ff, 32'd0};
         default: pp_shift = {pp_ff, 64'd0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 3'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req.start) begin
         ua_ff   <= req.a[63] ? 64'd0 - req.a : req.a;
         ub_ff   <= req.b[63] ? 64'd0 - req.b : req.b;
         neg_ff  <= req.a[63] ^ req.b[63];
         frac_ff <= req.frac_shift;
         acc_ff  <= '0;
      end else if (busy_ff) begin
         if (cnt_ff < 3'd4) begin
            pp_ff  <= 64'(pa) * 64'(pb);
            pos_ff <= 2'(cnt_ff[0]) + 2'(cnt_ff[1]);
         end
         if (cnt_ff != 3'd0) acc_ff <= acc_ff + pp_shift;
      end
   end

   // truncate toward zero, saturate to signed 64
   always_comb begin
      mag_sh = frac_ff ? (acc_ff >> FRAC_BITS) : acc_ff;
      lo_mag = mag_sh[63:0];
      rsp.done = done_ff;
      if (neg_ff) begin
         if (mag_sh[127:64] != 64'd0 || lo_mag[63]) rsp.fx = wlsm_pkg::S64_MIN;
         else rsp.fx = 64'd0 - lo_mag;
      end else begin
         if (mag_sh[127:64] != 64'd0 || lo_mag[63]) rsp.fx = wlsm_pkg::S64_MAX;
         else rsp.fx = lo_mag;
      end
      rsp.lo = neg_ff ? 64'd0 - acc_ff[63:0] : acc_ff[63:0];
   end

endmodule

/* sv/wlsm_div.sv */
// Restoring divider, one quotient bit per cycle, signed numerator over
// positive divisor, quotient truncated toward zero.
module wlsm_div (
   input  logic                  clock,
   input  logic                  reset,
   input  wlsm_pkg::div_req_type req,
   output wlsm_pkg::div_rsp_type rsp
);
   logic [63:0] nq_ff, rem_ff, den_ff;
   logic        neg_ff, busy_ff, done_ff;
   logic [5:0]  cnt_ff;
   logic [64:0] rem_sh;
   logic        fits;

   always_comb begin
      rem_sh   = {rem_ff, nq_ff[63]};
      fits     = rem_sh >= {1'b0, den_ff};
      rsp.done = done_ff;
      rsp.quo  = neg_ff ? 64'd0 - nq_ff : nq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         nq_ff  <= req.num[63] ? 64'd0 - req.num : req.num;
         neg_ff <= req.num[63];
         den_ff <= req.den;
         rem_ff <= 64'd0;
      end else if (busy_ff) begin
         rem_ff <= fits ? 64'(rem_sh - {1'b0, den_ff}) : rem_sh[63:0];
         nq_ff  <= {nq_ff[62:0], fits};
      end
   end

endmodule

/* sv/weighted_linear_statistic_moments_unit.sv */
// Weighted linear statistic with conditional moments. Observations (x, integer
// weight, up to four influence columns) load one word per cycle into on-chip
// stores while req_stall stays low. The word marked last_observation starts a
// run and req_stall stays high until its final result is taken. A run makes
// two passes over the stored observations and then emits q statistics, q
// expectations and q*q covariances (or, after the first pass alone, one error
// word if the weight total is at most one), all in signed fixed point with
// FRAC_BITS fraction bits and saturating sums. Every product goes through one
// shared multiplier (four 32x32 partial products) and every quotient through
// one bit-serial divider. A run also waits out any result stalls; zero-weight
// observations are skipped in each pass.
module weighted_linear_statistic_moments_unit #(
   parameter int MAX_OBS   = 1024,
   parameter int Q_MAX     = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  wlsm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wlsm_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_data
);
   localparam int AW    = $clog2(MAX_OBS);
   localparam int CNT_W = $clog2(MAX_OBS + 1);
   localparam int SW_W  = $clog2(MAX_OBS + 1) + 16;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_P1_RD  = 5'd1;
   localparam logic [4:0] S_P1_CHK = 5'd2;
   localparam logic [4:0] S_P1_T   = 5'd3;
   localparam logic [4:0] S_P1_X2  = 5'd4;
   localparam logic [4:0] S_P1_ISJ = 5'd5;
   localparam logic [4:0] S_P1_TJ  = 5'd6;
   localparam logic [4:0] S_P1_MJ  = 5'd7;
   localparam logic [4:0] S_P1_END = 5'd8;
   localparam logic [4:0] S_MDIV   = 5'd9;
   localparam logic [4:0] S_MQ     = 5'd10;
   localparam logic [4:0] S_P2_RD  = 5'd11;
   localparam logic [4:0] S_P2_CHK = 5'd12;
   localparam logic [4:0] S_P2_ISJ = 5'd13;
   localparam logic [4:0] S_P2_TJ  = 5'd14;
   localparam logic [4:0] S_P2_ISK = 5'd15;
   localparam logic [4:0] S_P2_C   = 5'd16;
   localparam logic [4:0] S_CDIV   = 5'd17;
   localparam logic [4:0] S_CQ     = 5'd18;
   localparam logic [4:0] S_DG     = 5'd19;
   localparam logic [4:0] S_DH     = 5'd20;
   localparam logic [4:0] S_DD     = 5'd21;
   localparam logic [4:0] S_FQ     = 5'd22;
   localparam logic [4:0] S_E0     = 5'd23;
   localparam logic [4:0] S_E1     = 5'd24;
   localparam logic [4:0] S_E1R    = 5'd25;
   localparam logic [4:0] S_E2     = 5'd26;
   localparam logic [4:0] S_E2R    = 5'd27;
   localparam logic [4:0] S_MWAIT  = 5'd28;
   localparam logic [4:0] S_DWAIT  = 5'd29;
   localparam logic [4:0] S_OUT    = 5'd30;

   // observation stores
   logic signed [31:0]          x_mem [MAX_OBS];
   logic [15:0]                 w_mem [MAX_OBS];
   logic [Q_MAX-1:0][31:0]      y_mem [MAX_OBS];
   logic signed [31:0]          x_rd_ff;
   logic [15:0]                 w_rd_ff;
   logic [Q_MAX-1:0][31:0]      y_rd_ff;
   logic [wlsm_pkg::NCOL-1:0][31:0] ycol;

   logic [4:0]         state_ff, state_in, ret_ff, ret_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in, i_ff, i_in;
   logic [1:0]         j_ff, j_in, k_ff, k_in, qlast_ff, qlast_in, msel;
   logic [2:0]         qcfg_ff;
   logic [SW_W-1:0]    sw_ff, sw_in;
   logic signed [63:0] swx_ff, swx_in, swx2_ff, swx2_in, t_ff, t_in, tj_ff, tj_in;
   logic signed [63:0] d_ff, d_in, f_ff, f_in;
   logic signed [63:0] mfx_ff, mfx_in, mlo_ff, mlo_in, dres_ff, dres_in;
   logic signed [63:0] stat_ff [4];
   logic signed [63:0] stat_in [4];
   logic signed [63:0] mean_ff [4];
   logic signed [63:0] mean_in [4];
   logic signed [63:0] cov_ff [16];
   logic signed [63:0] cov_in [16];
   logic               rsp_valid_ff, rsp_valid_in;
   wlsm_pkg::rsp_type  rsp_data_ff, rsp_data_in;
   wlsm_pkg::mul_req_type mreq;
   wlsm_pkg::mul_rsp_type mrsp;
   wlsm_pkg::div_req_type dreq;
   wlsm_pkg::div_rsp_type drsp;

   logic               req_acc, store_ok, rd_en;
   logic signed [63:0] w64, x64, yj64, ysel64, dev, sw64;
   logic [3:0]         jk;

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign store_ok  = (cnt_ff < CNT_W'(MAX_OBS));
   assign rd_en     = (state_ff == S_P1_RD) || (state_ff == S_P2_RD);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign ycol      = {req_data.y_col3, req_data.y_col2, req_data.y_col1, req_data.y_col0};

   // store write on accept, registered read during the passes
   always_ff @(posedge clock) begin
      if (req_acc && store_ok) begin
         x_mem[cnt_ff[AW-1:0]] <= req_data.x_value;
         w_mem[cnt_ff[AW-1:0]] <= req_data.case_weight;
         y_mem[cnt_ff[AW-1:0]] <= ycol[Q_MAX-1:0];
      end
      if (rd_en) begin
         x_rd_ff <= x_mem[i_ff[AW-1:0]];
         w_rd_ff <= w_mem[i_ff[AW-1:0]];
         y_rd_ff <= y_mem[i_ff[AW-1:0]];
      end
   end

   wlsm_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .rsp   (mrsp)
   );

   wlsm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   // operand selection
   always_comb begin
      msel   = (state_ff == S_P2_ISK) ? k_ff : j_ff;
      w64    = 64'(w_rd_ff);
      x64    = 64'(x_rd_ff);
      yj64   = 64'(signed'(y_rd_ff[j_ff]));
      ysel64 = 64'(signed'(y_rd_ff[msel]));
      dev    = ysel64 - mean_ff[msel];
      sw64   = 64'(sw_ff);
      jk     = {j_ff, k_ff};
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      qlast_in     = qlast_ff;
      sw_in        = sw_ff;
      swx_in       = swx_ff;
      swx2_in      = swx2_ff;
      t_in         = t_ff;
      tj_in        = tj_ff;
      d_in         = d_ff;
      f_in         = f_ff;
      mfx_in       = mfx_ff;
      mlo_in       = mlo_ff;
      dres_in      = dres_ff;
      stat_in      = stat_ff;
      mean_in      = mean_ff;
      cov_in       = cov_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mreq         = '0;
      dreq         = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (store_ok) cnt_in = cnt_ff + CNT_W'(1);
               if (req_data.last_observation) begin
                  i_in    = '0;
                  sw_in   = '0;
                  swx_in  = '0;
                  swx2_in = '0;
                  for (int c = 0; c < 4; c++) begin
                     stat_in[c] = '0;
                     mean_in[c] = '0;
                  end
                  for (int c = 0; c < 16; c++) cov_in[c] = '0;
                  if (qcfg_ff == 3'd0) qlast_in = 2'd0;
                  else if (qcfg_ff > 3'(Q_MAX)) qlast_in = 2'(Q_MAX - 1);
                  else qlast_in = 2'(qcfg_ff - 3'd1);
                  state_in = S_P1_RD;
               end
            end
         end
         // first pass: weight total, sums, statistic, mean numerators
         S_P1_RD: state_in = (i_ff == cnt_ff) ? S_P1_END : S_P1_CHK;
         S_P1_CHK: begin
            if (w_rd_ff == 16'd0) begin
               i_in     = i_ff + CNT_W'(1);
               state_in = S_P1_RD;
            end else begin
               sw_in    = sw_ff + SW_W'(w_rd_ff);
               mreq     = '{start: 1'b1, frac_shift: 1'b0, a: w64, b: x64};
               ret_in   = S_P1_T;
               state_in = S_MWAIT;
            end
         end
         S_P1_T: begin
            t_in     = mlo_ff;
            swx_in   = wlsm_pkg::sat_add(swx_ff, mlo_ff);
            mreq     = '{start: 1'b1, frac_shift: 1'b1, a: mlo_ff, b: x64};
            ret_in   = S_P1_X2;
            state_in = S_MWAIT;
         end
         S_P1_X2: begin
            swx2_in  = wlsm_pkg::sat_add(swx2_ff, mfx_ff);
            j_in     = 2'd0;
            state_in = S_P1_ISJ;
         end
         S_P1_ISJ: begin
            mreq     = '{start: 1'b1, frac_shift: 1'b1, a: t_ff, b: yj64};
            ret_in   = S_P1_TJ;
            state_in = S_MWAIT;
         end
         S_P1_TJ: begin
            stat_in[j_ff] = wlsm_pkg::sat_add(stat_ff[j_ff], mfx_ff);
            mreq     = '{start: 1'b1, frac_shift: 1'b0, a: w64, b: yj64};
            ret_in   = S_P1_MJ;
            state_in = S_MWAIT;
         end
         S_P1_MJ: begin
            mean_in[j_ff] = wlsm_pkg::sat_add(mean_ff[j_ff], mlo_ff);
            if (j_ff == qlast_ff) begin
               i_in     = i_ff + CNT_W'(1);
               state_in = S_P1_RD;
            end else begin
               j_in     = j_ff + 2'd1;
               state_in = S_P1_ISJ;
            end
         end
         S_P1_END: begin
            if (sw_ff <= SW_W'(1)) begin
               cnt_in       = '0;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{result_kind: wlsm_pkg::KIND_ERR, row_index: 2'd0,
                                col_index: 2'd0, result_value: 64'sd0, last_result: 1'b1};
               ret_in       = S_IDLE;
               state_in     = S_OUT;
            end else begin
               j_in     = 2'd0;
               state_in = S_MDIV;
            end
         end
         // means
         S_MDIV: begin
            dreq     = '{start: 1'b1, num: mean_ff[j_ff], den: sw64};
            ret_in   = S_MQ;
            state_in = S_DWAIT;
         end
         S_MQ: begin
            mean_in[j_ff] = dres_ff;
            if (j_ff == qlast_ff) begin
               i_in     = '0;
               state_in = S_P2_RD;
            end else begin
               j_in     = j_ff + 2'd1;
               state_in = S_MDIV;
            end
         end
         // second pass: covariance sums
         S_P2_RD: begin
            if (i_ff == cnt_ff) begin
               j_in     = 2'd0;
               k_in     = 2'd0;
               state_in = S_CDIV;
            end else begin
               state_in = S_P2_CHK;
            end
         end
         S_P2_CHK: begin
            if (w_rd_ff == 16'd0) begin
               i_in     = i_ff + CNT_W'(1);
               state_in = S_P2_RD;
            end else begin
               j_in     = 2'd0;
               state_in = S_P2_ISJ;
            end
         end
         S_P2_ISJ: begin
            mreq     = '{start: 1'b1, frac_shift: 1'b0, a: w64, b: dev};
            ret_in   = S_P2_TJ;
            state_in = S_MWAIT;
         end
         S_P2_TJ: begin
            tj_in    = mlo_ff;
            k_in     = 2'd0;
            state_in = S_P2_ISK;
         end
         S_P2_ISK: begin
            mreq     = '{start: 1'b1, frac_shift: 1'b1, a: tj_ff, b: dev};
            ret_in   = S_P2_C;
            state_in = S_MWAIT;
         end
         S_P2_C: begin
            cov_in[jk] = wlsm_pkg::sat_add(cov_ff[jk], mfx_ff);
            if (k_ff != qlast_ff) begin
               k_in     = k_ff + 2'd1;
               state_in = S_P2_ISK;
            end else if (j_ff != qlast_ff) begin
               j_in     = j_ff + 2'd1;
               state_in = S_P2_ISJ;
            end else begin
               i_in     = i_ff + CNT_W'(1);
               state_in = S_P2_RD;
            end
         end
         // covariance scaling by the weight total
         S_CDIV: begin
            dreq     = '{start: 1'b1, num: cov_ff[jk], den: sw64};
            ret_in   = S_CQ;
            state_in = S_DWAIT;
         end
         S_CQ: begin
            cov_in[jk] = dres_ff;
            if (k_ff != qlast_ff) begin
               k_in     = k_ff + 2'd1;
               state_in = S_CDIV;
            end else if (j_ff != qlast_ff) begin
               j_in     = j_ff + 2'd1;
               k_in     = 2'd0;
               state_in = S_CDIV;
            end else begin
               state_in = S_DG;
            end
         end
         // variance factor F = (sw*swx2 - swx^2) / (sw - 1)
         S_DG: begin
            mreq     = '{start: 1'b1, frac_shift: 1'b0, a: swx2_ff, b: sw64};
            ret_in   = S_DH;
            state_in = S_MWAIT;
         end
         S_DH: begin
            d_in     = mfx_ff;
            mreq     = '{start: 1'b1, frac_shift: 1'b1, a: swx_ff, b: swx_ff};
            ret_in   = S_DD;
            state_in = S_MWAIT;
         end
         S_DD: begin
            dreq     = '{start: 1'b1, num: wlsm_pkg::sat_sub(d_ff, mfx_ff),
                         den: sw64 - 64'sd1};
            ret_in   = S_FQ;
            state_in = S_DWAIT;
         end
         S_FQ: begin
            f_in     = dres_ff;
            j_in     = 2'd0;
            state_in = S_E0;
         end
         // results
         S_E0: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{result_kind: wlsm_pkg::KIND_STAT, row_index: j_ff,
                             col_index: 2'd0, result_value: stat_ff[j_ff], last_result: 1'b0};
            state_in     = S_OUT;
            if (j_ff != qlast_ff) begin
               j_in   = j_ff + 2'd1;
               ret_in = S_E0;
            end else begin
               j_in   = 2'd0;
               ret_in = S_E1;
            end
         end
         S_E1: begin
            mreq     = '{start: 1'b1, frac_shift: 1'b1, a: swx_ff, b: mean_ff[j_ff]};
            ret_in   = S_E1R;
            state_in = S_MWAIT;
         end
         S_E1R: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{result_kind: wlsm_pkg::KIND_EXP, row_index: j_ff,
                             col_index: 2'd0, result_value: mfx_ff, last_result: 1'b0};
            state_in     = S_OUT;
            if (j_ff != qlast_ff) begin
               j_in   = j_ff + 2'd1;
               ret_in = S_E1;
            end else begin
               j_in   = 2'd0;
               k_in   = 2'd0;
               ret_in = S_E2;
            end
         end
         S_E2: begin
            mreq     = '{start: 1'b1, frac_shift: 1'b1, a: cov_ff[jk], b: f_ff};
            ret_in   = S_E2R;
            state_in = S_MWAIT;
         end
         S_E2R: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{result_kind: wlsm_pkg::KIND_COV, row_index: j_ff,
                             col_index: k_ff, result_value: mfx_ff,
                             last_result: (j_ff == qlast_ff) && (k_ff == qlast_ff)};
            state_in     = S_OUT;
            ret_in       = S_E2;
            if (k_ff != qlast_ff) begin
               k_in = k_ff + 2'd1;
            end else if (j_ff != qlast_ff) begin
               j_in = j_ff + 2'd1;
               k_in = 2'd0;
            end else begin
               cnt_in = '0;
               ret_in = S_IDLE;
            end
         end
         // waits on the shared units and the output word
         S_MWAIT: begin
            if (mrsp.done) begin
               mfx_in   = mrsp.fx;
               mlo_in   = mrsp.lo;
               state_in = ret_ff;
            end
         end
         S_DWAIT: begin
            if (drsp.done) begin
               dres_in  = drsp.quo;
               state_in = ret_ff;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = ret_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         qcfg_ff      <= 3'd4;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) qcfg_ff <= csr_data;
      end
   end

   // working values
   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      qlast_ff    <= qlast_in;
      sw_ff       <= sw_in;
      swx_ff      <= swx_in;
      swx2_ff     <= swx2_in;
      t_ff        <= t_in;
      tj_ff       <= tj_in;
      d_ff        <= d_in;
      f_ff        <= f_in;
      mfx_ff      <= mfx_in;
      mlo_ff      <= mlo_in;
      dres_ff     <= dres_in;
      stat_ff     <= stat_in;
      mean_ff     <= mean_in;
      cov_ff      <= cov_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* sv/wlsm_checker.sv */
// Port-level checks for the moments unit.
module wlsm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input wlsm_pkg::rsp_type rsp_data
);
   // no result word right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // input side is held while a result word is offered
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted while a result is pending");

   // final word of a run frees the block
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.last_result |=> !rsp_valid)
      else $error("result after final word of run");

   // stalled result word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");
endmodule

bind weighted_linear_statistic_moments_unit wlsm_checker u_wlsm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
